[rtl/core/mtsw_pkg.sv]
// ============================================================================
// mtsw_pkg: shared types and constants of the monitor table slot writer
// Holds the mesh and table geometry, the input and result word layouts, the
// status codes, the sequencer states and the slot store command bundle.
// ============================================================================
package mtsw_pkg;

    // Mesh and table geometry.
    localparam int MESH_WIDTH    = 4;
    localparam int NUM_PE        = 16;
    localparam int SLOTS_PER_PE  = 4;
    localparam int NUM_SERVICES  = 5;
    localparam int NUM_BASE_REGS = 5;
    localparam int TABLE_DEPTH   = NUM_PE * SLOTS_PER_PE;

    // Widths of internal values.
    localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ROW_RAW_W = $clog2(255 + 255 * MESH_WIDTH + 1);
    localparam int CFG_IDX_W = 3;
    localparam int TASK_W    = 16;
    localparam int WORD_W    = 32;

    // Opcode of a clear command; any other opcode is a monitor message.
    localparam logic OP_CLEAR = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_WRITTEN   = 3'd0,
        ST_NO_TABLE  = 3'd1,
        ST_ROW_FULL  = 3'd2,
        ST_ROW_RANGE = 3'd3,
        ST_CLEARED   = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_CMP,
        S_ADDR,
        S_EMIT_PAY,
        S_EMIT_TASK,
        S_EMIT_STATUS
    } state_t;

    // Input word.
    typedef struct packed {
        logic              opcode;
        logic [2:0]        service;
        logic [7:0]        source_x;
        logic [7:0]        source_y;
        logic [TASK_W-1:0] task_id;
        logic [WORD_W-1:0] payload;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [WORD_W-1:0] write_address;
        logic [WORD_W-1:0] write_data;
        logic              mem_write;
        logic [2:0]        status;
        logic              last;
    } out_word_t;

    // Commands from the sequencer to the slot store.
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
        logic              wr_en;
        logic              clr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [TASK_W-1:0] wr_task;
    } store_cmd_t;

    // Registered read response of the slot store.
    typedef struct packed {
        logic              rd_used;
        logic [TASK_W-1:0] rd_task;
    } store_rsp_t;

endpackage

[rtl/core/mtsw_slot_store.sv]
// ============================================================================
// mtsw_slot_store: slot task memory and slot used flags
// One read port with registered data and one write port. The used flags live
// in flip-flops that reset clears, so every slot starts out free.
// ============================================================================
module mtsw_slot_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mtsw_pkg::store_cmd_t  cmd,
    output mtsw_pkg::store_rsp_t  rsp
);
    import mtsw_pkg::*;

    logic [TASK_W-1:0]      task_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] used_reg;
    logic [TASK_W-1:0]      rd_task_reg;
    logic                   rd_used_reg;

    // Task memory: claim writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            task_mem[cmd.wr_idx] <= cmd.wr_task;
        end
        if (cmd.rd_en)
        begin
            rd_task_reg <= task_mem[cmd.rd_idx];
            rd_used_reg <= used_reg[cmd.rd_idx];
        end
    end

    // Used flags: set on a claim, cleared on a clear command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            used_reg[cmd.wr_idx] <= 1'b1;
        end
        else if (cmd.clr_en)
        begin
            used_reg[cmd.wr_idx] <= 1'b0;
        end
    end

    assign rsp.rd_used = rd_used_reg;
    assign rsp.rd_task = rd_task_reg;

endmodule

[rtl/core/mtsw_ctrl.sv]
// ============================================================================
// mtsw_ctrl: sequencer of the monitor table slot writer
// Decodes one input word, walks the slots one read at a time through a single
// compare unit, claims or frees a slot, and hands result words to the output.
// ============================================================================
module mtsw_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mtsw_pkg::in_word_t            in_word,
    input  logic [mtsw_pkg::WORD_W-1:0]   sel_base,
    output logic                          emit_valid,
    output mtsw_pkg::out_word_t           emit_word,
    input  logic                          emit_ready,
    output mtsw_pkg::store_cmd_t          store_cmd,
    input  mtsw_pkg::store_rsp_t          store_rsp
);
    import mtsw_pkg::*;

    state_t                 state_reg, state_next;
    logic                   op_reg, op_next;
    logic [TASK_W-1:0]      task_reg, task_next;
    logic [WORD_W-1:0]      payload_reg, payload_next;
    logic [WORD_W-1:0]      base_reg, base_next;
    logic [ROW_RAW_W-1:0]   row_raw_reg, row_raw_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       last_idx_reg, last_idx_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [WORD_W-1:0]      addr_reg, addr_next;
    status_t                status_reg, status_next;

    logic                   hit;
    logic                   at_last;
    logic [IDX_W-1:0]       first_idx;
    logic [IDX_W-1:0]       claim_idx;

    // Compare unit shared by every slot visit.
    assign hit       = store_rsp.rd_used && (store_rsp.rd_task == task_reg);
    assign at_last   = (idx_reg == last_idx_reg);
    assign first_idx = IDX_W'(row_raw_reg * SLOTS_PER_PE);
    assign claim_idx = free_found_reg ? free_idx_reg : idx_reg;

    // Next state, datapath updates and outputs.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        task_next       = task_reg;
        payload_next    = payload_reg;
        base_next       = base_reg;
        row_raw_next    = row_raw_reg;
        idx_next        = idx_reg;
        last_idx_next   = last_idx_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        addr_next       = addr_reg;
        status_next     = status_reg;

        in_ready   = 1'b0;
        emit_valid = 1'b0;
        emit_word  = '0;
        store_cmd  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next      = in_word.opcode;
                    task_next    = in_word.task_id;
                    payload_next = in_word.payload;
                    base_next    = sel_base;
                    row_raw_next = ROW_RAW_W'(in_word.source_x)
                                 + ROW_RAW_W'(in_word.source_y) * ROW_RAW_W'(MESH_WIDTH);
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                free_found_next = 1'b0;
                if (op_reg == OP_CLEAR)
                begin
                    idx_next      = '0;
                    last_idx_next = IDX_W'(TABLE_DEPTH - 1);
                    state_next    = S_READ;
                end
                else if (base_reg == '0)
                begin
                    status_next = ST_NO_TABLE;
                    state_next  = S_EMIT_STATUS;
                end
                else if (32'(row_raw_reg) >= NUM_PE)
                begin
                    status_next = ST_ROW_RANGE;
                    state_next  = S_EMIT_STATUS;
                end
                else
                begin
                    idx_next      = first_idx;
                    last_idx_next = IDX_W'(first_idx + SLOTS_PER_PE - 1);
                    state_next    = S_READ;
                end
            end

            S_READ:
            begin
                store_cmd.rd_en  = 1'b1;
                store_cmd.rd_idx = idx_reg;
                state_next       = S_CMP;
            end

            S_CMP:
            begin
                if (op_reg == OP_CLEAR)
                begin
                    // Clear command: free the first matching slot of the table.
                    if (hit)
                    begin
                        store_cmd.clr_en = 1'b1;
                        store_cmd.wr_idx = idx_reg;
                        status_next      = ST_CLEARED;
                        state_next       = S_EMIT_STATUS;
                    end
                    else if (at_last)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_EMIT_STATUS;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
                else
                begin
                    // Monitor message: a match wins, else the first free slot.
                    if (hit)
                    begin
                        hit_idx_next = idx_reg;
                        state_next   = S_ADDR;
                    end
                    else if (at_last)
                    begin
                        if (free_found_reg || !store_rsp.rd_used)
                        begin
                            store_cmd.wr_en   = 1'b1;
                            store_cmd.wr_idx  = claim_idx;
                            store_cmd.wr_task = task_reg;
                            hit_idx_next      = claim_idx;
                            state_next        = S_ADDR;
                        end
                        else
                        begin
                            status_next = ST_ROW_FULL;
                            state_next  = S_EMIT_STATUS;
                        end
                    end
                    else
                    begin
                        if (!store_rsp.rd_used && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end

            S_ADDR:
            begin
                addr_next  = base_reg + WORD_W'({hit_idx_reg, 3'b000});
                state_next = S_EMIT_PAY;
            end

            S_EMIT_PAY:
            begin
                emit_valid              = 1'b1;
                emit_word.write_address = addr_reg + WORD_W'(4);
                emit_word.write_data    = payload_reg;
                emit_word.mem_write     = 1'b1;
                emit_word.status        = ST_WRITTEN;
                emit_word.last          = 1'b0;
                if (emit_ready)
                begin
                    state_next = S_EMIT_TASK;
                end
            end

            S_EMIT_TASK:
            begin
                emit_valid              = 1'b1;
                emit_word.write_address = addr_reg;
                emit_word.write_data    = WORD_W'(task_reg);
                emit_word.mem_write     = 1'b1;
                emit_word.status        = ST_WRITTEN;
                emit_word.last          = 1'b1;
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            S_EMIT_STATUS:
            begin
                emit_valid       = 1'b1;
                emit_word.status = status_reg;
                emit_word.last   = 1'b1;
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        task_reg       <= task_next;
        payload_reg    <= payload_next;
        base_reg       <= base_next;
        row_raw_reg    <= row_raw_next;
        idx_reg        <= idx_next;
        last_idx_reg   <= last_idx_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        free_found_reg <= free_found_next;
        addr_reg       <= addr_next;
        status_reg     <= status_next;
    end

endmodule

[rtl/core/monitor_table_slot_writer.sv]
// ============================================================================
// monitor_table_slot_writer: monitor message table slot writer
// Keeps the per-PE slot table, turns monitor messages into two memory word
// writes into the selected service table, and frees slots on clear commands.
//
//   channel  signals                          direction  word
//   in       in_valid, in_ready, in_word      input      in_word_t
//   out      out_valid, out_ready, out_word   output     out_word_t
//   cfg      cfg_valid, cfg_ready,            input      index and base data
//            cfg_index, cfg_data
//
// A monitor message ends in two memory writes or in one status result; a clear
// command ends in one status result. The slot memory has a single, registered
// read port, so each slot visit is a read and a compare. A new item is taken
// only once the last result of the one before has left the sequencer. Reset
// clears the base registers and marks every slot free. Results sit in an
// output register; a stalled output holds the sequencer. Configuration writes
// are always taken.
// ============================================================================
module monitor_table_slot_writer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  mtsw_pkg::in_word_t               in_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output mtsw_pkg::out_word_t              out_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mtsw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtsw_pkg::WORD_W-1:0]      cfg_data
);
    import mtsw_pkg::*;

    logic [WORD_W-1:0] base_regs_reg [NUM_BASE_REGS];
    logic [WORD_W-1:0] sel_base;
    logic              out_valid_reg;
    out_word_t         out_word_reg;
    logic              emit_valid;
    out_word_t         emit_word;
    logic              emit_ready;
    store_cmd_t        store_cmd;
    store_rsp_t        store_rsp;

    // Table base registers; writes beyond the register list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BASE_REGS; i++)
            begin
                base_regs_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (32'(cfg_index) < NUM_BASE_REGS))
        begin
            base_regs_reg[cfg_index] <= cfg_data;
        end
    end

    // Service to base selection; a service without a register has no table.
    always_comb
    begin
        if ((32'(in_word.service) >= NUM_SERVICES) || (32'(in_word.service) >= NUM_BASE_REGS))
        begin
            sel_base = '0;
        end
        else
        begin
            sel_base = base_regs_reg[in_word.service];
        end
    end

    // Sequencer.
    mtsw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .sel_base   (sel_base),
        .emit_valid (emit_valid),
        .emit_word  (emit_word),
        .emit_ready (emit_ready),
        .store_cmd  (store_cmd),
        .store_rsp  (store_rsp)
    );

    // Slot table.
    mtsw_slot_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (store_cmd),
        .rsp   (store_rsp)
    );

    // Output register.
    assign emit_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_ready)
        begin
            out_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid && emit_ready)
        begin
            out_word_reg <= emit_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef SYNTHESIS
    // A result that is not a memory write carries zero address and data and ends its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.mem_write) |->
            (out_word.write_address == '0 && out_word.write_data == '0 && out_word.last))
        else $error("non-write result with address, data or missing last");

    // Memory writes come exactly with the written status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.mem_write == (out_word.status == ST_WRITTEN)))
        else $error("write flag and status disagree");

    // The block never takes a new item while the first of a write pair is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.last) |-> !in_ready)
        else $error("input taken while a write pair is incomplete");

    // A payload write is followed, once taken, by the task id write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_word.mem_write && !out_word.last) |=>
            (out_valid && out_word.last && out_word.mem_write))
        else $error("payload write not followed by task id write");
`endif

endmodule
